@@ rtl/core/ulpu_pkg.sv @@
// shared types, constants and sample arithmetic for the mu-law/pcm unpacker
package ulpu_pkg;

    localparam int unsigned SampleW  = 16;
    localparam int unsigned WordW    = 32;
    localparam int unsigned NumSlots = 4;

    typedef logic signed [SampleW-1:0] t_sample;
    typedef t_sample t_dec [NumSlots];

    // configuration register indexes
    typedef enum logic {
        REG_SAMPLE_CODING  = 1'b0,
        REG_UPSAMPLE_RATIO = 1'b1
    } t_cfg_reg;

    // upsample ratio codes, code 3 behaves as 4x
    localparam logic [1:0] RATIO_1X = 2'd0;
    localparam logic [1:0] RATIO_2X = 2'd1;

    localparam logic CODING_ULAW = 1'b0;
    localparam logic CODING_PCM  = 1'b1;

    localparam logic [7:0] UlawBias = 8'd132;

    // control handed from the input stage to the emitter
    typedef struct packed {
        logic       load;
        logic       restart;
        logic       pcm;
        logic [1:0] ratio;
    } t_load_ctl;

    // g.711 mu-law expansion
    function automatic t_sample ulaw_expand(input logic [7:0] code);
        logic [7:0]  c;
        logic [7:0]  base;
        logic [14:0] mag;
        c    = ~code;
        base = 8'({1'b0, c[3:0], 3'b000}) + UlawBias;
        mag  = (15'(base) << c[6:4]) - 15'(UlawBias);
        return c[7] ? t_sample'(16'd0 - {1'b0, mag}) : t_sample'({1'b0, mag});
    endfunction

    // floor((wa*a + (4-wa)*b) / 4), computed as (4b + wa*(a-b)) >>> 2
    function automatic t_sample blend(input t_sample a, input t_sample b,
                                      input logic [1:0] wa);
        logic signed [18:0] d;
        logic signed [18:0] p;
        logic signed [18:0] s;
        d = 19'(a) - 19'(b);
        p = d * $signed({17'd0, wa});
        s = (19'(b) <<< 2) + p;
        return s[17:2];
    endfunction

endpackage

@@ rtl/core/ulaw_pcm_word_unpack_upsampler_unit.sv @@
// top level: config registers, input word register, decode and sample emitter
//
// Takes one 32-bit word holding four mu-law bytes or two 16-bit pcm samples
// (low sample first) and streams out signed 16-bit samples, one per cycle
// unless m_tready stalls the output, with 1 or 3 linearly interpolated
// points before each decoded sample in 2x or 4x mode. A word yields mu-law
// 4, 8 or 16 samples, pcm 2, 4 or 8, moved out through the single output
// register. The input register takes the next word while the current one is
// still being emitted, so words flow with no gaps between them; a word
// passes through the input register and the emitter's registers before its
// first sample reaches the output register. The last sample of each word is
// marked with m_tlast. Write the configuration only while no word is in flight.
module ulaw_pcm_word_unpack_upsampler_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [1:0]                 i_cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ulpu_pkg::WordW-1:0] s_tdata,   // [31:0] data_word
    input  logic                       s_tuser,   // [0] restart
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // [15:0] sample
    output logic                       m_tlast    // last_of_word
);
    import ulpu_pkg::*;

    logic             r_coding;
    logic [1:0]       r_ratio;
    logic             r_in_valid;
    logic [WordW-1:0] r_word;
    logic             r_restart;

    logic      take;
    t_load_ctl ctl;
    t_dec      dec;
    t_sample   sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coding <= CODING_ULAW;
            r_ratio  <= RATIO_1X;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SAMPLE_CODING:  r_coding <= i_cfg_data[0];
                REG_UPSAMPLE_RATIO: r_ratio  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                r_in_valid <= 1'b1;
                r_word     <= s_tdata;
                r_restart  <= s_tuser;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        ctl.load    = r_in_valid && take;
        ctl.restart = r_restart;
        ctl.pcm     = r_coding;
        ctl.ratio   = r_ratio;
    end

    ulpu_decode u_decode (
        .i_word (r_word),
        .i_pcm  (r_coding),
        .o_dec  (dec)
    );

    ulpu_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_dec    (dec),
        .o_take   (take),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_sample (sample),
        .o_last   (m_tlast)
    );

    assign m_tdata = 16'(sample);

endmodule

@@ rtl/core/ulpu_decode.sv @@
// splits a registered word into four mu-law or two pcm samples
module ulpu_decode (
    input  logic [ulpu_pkg::WordW-1:0] i_word,
    input  logic                       i_pcm,
    output ulpu_pkg::t_dec             o_dec
);
    import ulpu_pkg::*;

    always_comb begin
        if (i_pcm == CODING_PCM) begin
            o_dec[0] = t_sample'(i_word[15:0]);
            o_dec[1] = t_sample'(i_word[31:16]);
            o_dec[2] = '0;
            o_dec[3] = '0;
        end else begin
            for (int i = 0; i < NumSlots; i++) begin
                o_dec[i] = ulaw_expand(i_word[8*i +: 8]);
            end
        end
    end

endmodule

@@ rtl/core/ulpu_emit.sv @@
// steps through the decoded samples, inserts interpolated points, output register
module ulpu_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ulpu_pkg::t_load_ctl i_ctl,
    input  ulpu_pkg::t_dec      i_dec,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_ready,
    output ulpu_pkg::t_sample   o_sample,
    output logic                o_last
);
    import ulpu_pkg::*;

    logic       r_busy;
    logic [1:0] r_si;
    logic [1:0] r_ph;
    t_dec       r_dec;
    t_sample    r_base;
    logic       r_pcm;
    logic [1:0] r_ratio;
    t_sample    r_prev;
    logic       r_ovalid;
    t_sample    r_osample;
    logic       r_olast;

    logic       out_free;
    logic       step;
    logic [1:0] ph_last_code;
    logic       ph_last;
    logic       si_last;
    logic       word_end;
    logic [1:0] wa;
    t_sample    cur;
    t_sample    prv;
    t_sample    val;
    t_sample    base_in;
    t_sample    dec_last;

    always_comb begin
        unique case (r_ratio)
            RATIO_1X: ph_last_code = 2'd0;
            RATIO_2X: ph_last_code = 2'd1;
            default:  ph_last_code = 2'd3;
        endcase
        wa       = (r_ratio == RATIO_2X) ? 2'd2 : 2'd3 - r_ph;
        cur      = r_dec[r_si];
        prv      = (r_si == 2'd0) ? r_base : r_dec[r_si - 2'd1];
        ph_last  = (r_ph == ph_last_code);
        si_last  = (r_si == (r_pcm ? 2'd1 : 2'd3));
        word_end = ph_last && si_last;
        val      = ph_last ? cur : blend(prv, cur, wa);
        out_free = !r_ovalid || i_ready;
        step     = r_busy && out_free;
        o_take   = !r_busy || (step && word_end);
        base_in  = i_ctl.restart ? t_sample'(0) : r_prev;
        dec_last = i_ctl.pcm ? i_dec[1] : i_dec[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_si     <= '0;
            r_ph     <= '0;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_busy  <= 1'b1;
                r_si    <= '0;
                r_ph    <= '0;
                r_dec   <= i_dec;
                r_base  <= base_in;
                r_pcm   <= i_ctl.pcm;
                r_ratio <= i_ctl.ratio;
                // 1x leaves the history alone except for a restart
                r_prev  <= (i_ctl.ratio != RATIO_1X) ? dec_last : base_in;
            end else if (step) begin
                if (word_end) begin
                    r_busy <= 1'b0;
                end else if (ph_last) begin
                    r_ph <= '0;
                    r_si <= r_si + 2'd1;
                end else begin
                    r_ph <= r_ph + 2'd1;
                end
            end
            if (step) begin
                r_ovalid  <= 1'b1;
                r_osample <= val;
                r_olast   <= word_end;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_sample = r_osample;
    assign o_last   = r_olast;

endmodule

@@ rtl/core/ulpu_checker.sv @@
// port-level checks for the unpacker, bound to the top level
module ulpu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    // words accepted whose last sample has not yet been taken
    logic [2:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 3'(s_tvalid && s_tready)
                         - 3'(m_tvalid && m_tready && m_tlast);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> r_pending != 3'd0)
        else $error("sample shown with no word in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |-> r_pending <= 3'd2)
        else $error("more words in flight than the datapath holds");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind ulaw_pcm_word_unpack_upsampler_unit ulpu_checker u_ulpu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/sv/tb_ulaw_pcm_word_unpack_upsampler_unit.sv @@
// testbench for the mu-law/pcm word unpacker and linear upsampler
`timescale 1ns / 1ps

module tb_ulaw_pcm_word_unpack_upsampler_unit;
    import ulpu_pkg::*;

    localparam logic [1:0] RATIO_4X  = 2'd2;
    localparam logic [1:0] RATIO_SAT = 2'd3;
    localparam int unsigned CycleLimit = 800_000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned WordsPerPhase = 32;

    typedef struct {
        logic [31:0] word;
        logic        restart;
    } t_word_item;

    typedef struct {
        t_sample sample;
        logic    last;
    } t_out_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [1:0]  i_cfg_data = 2'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;   // [31:0] data_word
    logic        s_tuser = 1'b0;    // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] sample
    logic        m_tlast;           // last_of_word

    t_word_item  pending_words[$];
    t_out_sample pending_samples[$];

    // shadow of the block's registers and its held sample
    logic        sh_coding;
    logic [1:0]  sh_ratio;
    int          held_sample;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    int unsigned in_gap = 0;
    bit          in_quiet = 1'b0;
    int unsigned out_stall = 0;
    bit          out_quiet = 1'b0;

    ulaw_pcm_word_unpack_upsampler_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int ulaw_to_linear(input logic [7:0] code);
        logic [7:0] inv;
        int         mag;
        inv = ~code;
        mag = ((int'(inv[3:0]) * 8 + 132) << inv[6:4]) - 132;
        return inv[7] ? -mag : mag;
    endfunction

    // weighted point between a and b, rounded toward minus infinity
    function automatic int lerp_floor(input int a, input int b, input int wa);
        return (wa * a + (4 - wa) * b) >>> 2;
    endfunction

    task automatic predict_word(input logic [31:0] word, input logic restart);
        int dec[4];
        int n_dec;
        int prev;
        int k;
        if (restart) held_sample = 0;
        if (sh_coding == CODING_PCM) begin
            dec[0] = int'($signed(word[15:0]));
            dec[1] = int'($signed(word[31:16]));
            n_dec = 2;
        end else begin
            for (k = 0; k < 4; k++) dec[k] = ulaw_to_linear(word[8*k +: 8]);
            n_dec = 4;
        end
        prev = held_sample;
        for (k = 0; k < n_dec; k++) begin
            if (sh_ratio == RATIO_2X) begin
                pending_samples.push_back('{t_sample'(lerp_floor(prev, dec[k], 2)), 1'b0});
            end else if (sh_ratio != RATIO_1X) begin
                pending_samples.push_back('{t_sample'(lerp_floor(prev, dec[k], 3)), 1'b0});
                pending_samples.push_back('{t_sample'(lerp_floor(prev, dec[k], 2)), 1'b0});
                pending_samples.push_back('{t_sample'(lerp_floor(prev, dec[k], 1)), 1'b0});
            end
            pending_samples.push_back('{t_sample'(dec[k]), k == n_dec - 1});
            prev = dec[k];
        end
        // 1x leaves the held sample alone
        if (sh_ratio != RATIO_1X) held_sample = prev;
    endtask

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        error_count++;
    endtask

    // word driver
    always @(posedge i_clk) begin
        t_word_item item;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            in_gap = 0;
        end else begin
            if (s_tvalid && s_tready) predict_word(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    item = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item.word;
                    s_tuser <= item.restart;
                    in_gap = pick_gap(in_quiet);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sample monitor
    always @(posedge i_clk) begin
        t_out_sample want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            out_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch("unexpected sample", int'($signed(m_tdata)), 0);
                end else begin
                    want = pending_samples.pop_front();
                    if (m_tdata !== want.sample)
                        report_mismatch("sample", int'($signed(m_tdata)), int'(want.sample));
                    if (m_tlast !== want.last)
                        report_mismatch("last_of_word", int'(m_tlast), int'(want.last));
                end
            end
            if ($urandom_range(0, 59) == 0) out_quiet = !out_quiet;
            if (out_stall > 0) begin
                out_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                out_stall = pick_gap(out_quiet);
            end
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SAMPLE_CODING) sh_coding = val[0];
        else sh_ratio = val;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || s_tvalid || pending_samples.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic queue_word(input logic [31:0] word, input logic restart);
        pending_words.push_back('{word, restart});
    endtask

    function automatic logic [31:0] random_word();
        logic [7:0] special[10] = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01,
                                    8'h81, 8'h02, 8'h82, 8'h03, 8'h83};
        logic [31:0] w;
        int k;
        if ($urandom_range(0, 9) >= 2) return $urandom;
        for (k = 0; k < 4; k++) w[8*k +: 8] = special[$urandom_range(0, 9)];
        return w;
    endfunction

    initial begin
        int order[8];
        int i;
        int j;
        int tmp;
        logic junk;

        sh_coding = CODING_ULAW;
        sh_ratio = RATIO_1X;
        held_sample = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // mu-law at reset settings: peaks, both zeros, small codes
        queue_word(32'h00_80_FF_7F, 1'b0);
        queue_word(32'h83_03_82_02, 1'b0);
        queue_word(32'h81_01_80_00, 1'b1);
        wait_idle();

        // 2x: interpolation from the held sample, then a restart
        write_reg(REG_UPSAMPLE_RATIO, RATIO_2X);
        queue_word(32'h00_80_00_80, 1'b0);
        queue_word(32'h7F_01_FF_00, 1'b0);
        queue_word(32'h80_81_02_03, 1'b1);
        wait_idle();

        // 4x: full swing between opposite peaks
        write_reg(REG_UPSAMPLE_RATIO, RATIO_4X);
        queue_word(32'h80_00_80_00, 1'b0);
        queue_word(32'hFF_FF_00_80, 1'b0);
        queue_word(32'h00_00_00_00, 1'b1);
        wait_idle();

        // pcm at 4x, the unused ratio code, then 2x and 1x
        write_reg(REG_SAMPLE_CODING, {1'b0, CODING_PCM});
        queue_word(32'h7FFF_8000, 1'b1);
        queue_word(32'h8000_7FFF, 1'b0);
        wait_idle();
        write_reg(REG_UPSAMPLE_RATIO, RATIO_SAT);
        queue_word(32'hFFFF_0001, 1'b0);
        queue_word(32'h0000_FFFF, 1'b0);
        wait_idle();
        write_reg(REG_UPSAMPLE_RATIO, RATIO_2X);
        queue_word(32'h8001_7FFE, 1'b0);
        queue_word(32'h1234_EDCB, 1'b1);
        wait_idle();
        // 1x keeps the held sample, seen again once back at 2x
        write_reg(REG_UPSAMPLE_RATIO, RATIO_1X);
        queue_word(32'h8000_8000, 1'b0);
        queue_word(32'h7FFF_7FFF, 1'b0);
        wait_idle();
        write_reg(REG_UPSAMPLE_RATIO, RATIO_2X);
        queue_word(32'h0000_0000, 1'b0);
        wait_idle();

        // upper data bit on the coding register is dropped
        write_reg(REG_SAMPLE_CODING, {1'b1, CODING_ULAW});
        queue_word(32'h00_80_7F_FF, 1'b0);
        wait_idle();

        for (i = 0; i < 8; i++) order[i] = i;
        for (i = 7; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < 8; i++) begin
            junk = $urandom_range(0, 1);
            write_reg(REG_SAMPLE_CODING, {junk, 1'(order[i] % 2)});
            write_reg(REG_UPSAMPLE_RATIO, 2'(order[i] / 2));
            for (j = 0; j < WordsPerPhase; j++)
                queue_word(random_word(), $urandom_range(0, 11) == 0);
            wait_idle();
        end

        if (pending_samples.size() != 0)
            report_mismatch("samples never seen", 0, pending_samples.size());
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ ulaw_pcm_word_unpack_upsampler_unit.f @@
rtl/core/ulpu_pkg.sv
rtl/core/ulpu_decode.sv
rtl/core/ulpu_emit.sv
rtl/core/ulaw_pcm_word_unpack_upsampler_unit.sv
rtl/core/ulpu_checker.sv
tb/sv/tb_ulaw_pcm_word_unpack_upsampler_unit.sv
